### rtl/core/cfd_pkg.sv
// shared types, codes and constants for the command frame deframer
package cfd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned MAGIC_LEN = 8;
  localparam int unsigned MPOS_W    = $clog2(MAGIC_LEN + 1);
  localparam int unsigned MIDX_W    = $clog2(MAGIC_LEN);
  localparam int unsigned TLEN_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] FRAME_END = 8'h00;
  localparam logic [BYTE_W-1:0] SEP_ITEM  = 8'h01;
  localparam logic [BYTE_W-1:0] SEP_SUB   = 8'h02;

  localparam logic [BYTE_W-1:0] APP_CODE_RST   = 8'h00;
  localparam logic [BYTE_W-1:0] SHELL_CODE_RST = 8'h01;

  localparam logic [CFG_IDX_W-1:0] REG_APP_TYPE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SHELL_TYPE = 1'b1;

  localparam logic [TLEN_W-1:0] TLEN_MAX = 2'd2;

  typedef enum logic [2:0] {
    PH_MAGIC = 3'd0,
    PH_TYPE  = 3'd1,
    PH_CMD   = 3'd2,
    PH_PARA  = 3'd3,
    PH_SKIP  = 3'd4
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    K_TYPE      = 3'd0,
    K_CMD_BYTE  = 3'd1,
    K_CMD_END   = 3'd2,
    K_PAR_BYTE  = 3'd3,
    K_PAR_END   = 3'd4,
    K_FRAME_END = 3'd5,
    K_DROP      = 3'd6
  } kind_t;

  typedef struct packed {
    phase_t              phase;
    logic [MPOS_W-1:0]   mpos;
    logic                mmis;
    logic [TLEN_W-1:0]   tlen;
    logic [BYTE_W-1:0]   htype;
    logic                fopen;
  } parse_state_t;

  typedef struct packed {
    logic                valid;
    kind_t               kind;
    logic [BYTE_W-1:0]   value;
  } parse_res_t;

  function automatic parse_state_t clear_frame(phase_t ph);
    parse_state_t s;
    s.phase = ph;
    s.mpos  = '0;
    s.mmis  = 1'b0;
    s.tlen  = '0;
    s.htype = '0;
    s.fopen = 1'b0;
    return s;
  endfunction

  function automatic logic [BYTE_W-1:0] magic_byte(logic [MIDX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      3'd0:    b = 8'h47; // G
      3'd1:    b = 8'h4F; // O
      3'd2:    b = 8'h44; // D
      3'd3:    b = 8'h42; // B
      3'd4:    b = 8'h4C; // L
      3'd5:    b = 8'h45; // E
      3'd6:    b = 8'h53; // S
      default: b = 8'h53; // S
    endcase
    return b;
  endfunction

endpackage

### rtl/core/command_frame_deframer.sv
// command frame deframer top level: stream ports, state and result register
//
// usage:
//   in_*  : one stream byte per item in in_tdata
//   out_* : one parse event per item, kind in out_tuser, byte in out_tdata
//   cfg_* : write enable, register index and data for the two type codes,
//           written while the block is idle
// each accepted byte updates the parser state in the same cycle and, when
// it causes an event, loads the result register; the event shows on out_*
// in the cycle after the byte is accepted
// throughput is one byte per cycle unless a stalled receiver holds an event:
// the single parser step between the state and result registers sets it
// a byte is taken while the result register is empty or being emptied, so
// a stalled receiver holds the pending event and stops input only then
// synchronous reset clears the parser to the magic phase, empties the
// result register and sets the type codes to 0 (application) and 1 (shell)
module command_frame_deframer
  import cfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [BYTE_W-1:0]    in_tdata,   // in_byte
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [BYTE_W-1:0]    out_tdata,  // value
  output logic [KIND_W-1:0]    out_tuser,  // kind
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  parse_state_t      state_r;
  parse_state_t      state_nxt;
  parse_res_t        step_res;
  logic [BYTE_W-1:0] app_code_r;
  logic [BYTE_W-1:0] shell_code_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_value_r;
  kind_t             out_kind_r;
  logic              in_fire;
  logic              out_fire;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  cfd_step u_step (
    .st         (state_r),
    .byte_in    (in_tdata),
    .app_code   (app_code_r),
    .shell_code (shell_code_r),
    .st_nxt     (state_nxt),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      app_code_r   <= APP_CODE_RST;
      shell_code_r <= SHELL_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_APP_TYPE:   app_code_r   <= cfg_wdata;
        REG_SHELL_TYPE: shell_code_r <= cfg_wdata;
        default:        app_code_r   <= app_code_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clear_frame(PH_MAGIC);
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= step_res.valid;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && step_res.valid) begin
      out_kind_r  <= step_res.kind;
      out_value_r <= step_res.value;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_kind_r;

`ifndef SYNTHESIS
  // an accepted byte with an event always lands in the result register
  a_res_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && step_res.valid) |=> (out_tvalid && out_tuser == $past(step_res.kind)))
    else $error("event of accepted byte not loaded");

  // magic counter never passes the magic length
  a_mpos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.mpos <= MPOS_W'(MAGIC_LEN))
    else $error("magic position past saturation");

  // type length saturates below its top code
  a_tlen_sat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.tlen <= TLEN_MAX)
    else $error("type length past saturation");

  // magic tracking is cleared whenever the parser is past the magic phase
  a_magic_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase != PH_MAGIC) |-> (state_r.mpos == '0 && !state_r.mmis))
    else $error("magic tracking left set outside magic phase");
`endif

endmodule

### rtl/core/cfd_step.sv
// one byte step of the frame parser: next state and result
module cfd_step
  import cfd_pkg::*;
(
  input  parse_state_t      st,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic [BYTE_W-1:0] app_code,
  input  logic [BYTE_W-1:0] shell_code,
  output parse_state_t      st_nxt,
  output parse_res_t        res
);

  logic is_zero;
  logic is_sep;
  logic magic_ok;
  logic type_ok;

  assign is_zero  = (byte_in == FRAME_END);
  assign is_sep   = (byte_in == SEP_ITEM) || (byte_in == SEP_SUB);
  assign magic_ok = (st.mpos == MPOS_W'(MAGIC_LEN)) && !st.mmis;
  assign type_ok  = (st.tlen == TLEN_W'(1)) &&
                    ((st.htype == app_code) || (st.htype == shell_code));

  // next state
  always_comb begin
    st_nxt = st;
    unique case (st.phase)
      PH_MAGIC: begin
        if (is_zero) begin
          st_nxt = clear_frame(PH_MAGIC);
        end else if (is_sep) begin
          st_nxt = clear_frame(magic_ok ? PH_TYPE : PH_SKIP);
        end else if (st.mpos < MPOS_W'(MAGIC_LEN)) begin
          if (byte_in != magic_byte(st.mpos[MIDX_W-1:0])) begin
            st_nxt.mmis = 1'b1;
          end
          st_nxt.mpos = st.mpos + MPOS_W'(1);
        end else begin
          st_nxt.mmis = 1'b1;
        end
      end
      PH_TYPE: begin
        if (is_zero) begin
          st_nxt = clear_frame(PH_MAGIC);
        end else if (is_sep) begin
          if (type_ok) begin
            st_nxt.phase = PH_CMD;
            st_nxt.fopen = 1'b0;
          end else begin
            st_nxt = clear_frame(PH_SKIP);
          end
        end else begin
          if (st.tlen == '0) begin
            st_nxt.htype = byte_in;
          end
          if (st.tlen < TLEN_MAX) begin
            st_nxt.tlen = st.tlen + TLEN_W'(1);
          end
        end
      end
      PH_CMD: begin
        if (is_zero) begin
          st_nxt = clear_frame(PH_MAGIC);
        end else if (is_sep) begin
          if (st.fopen) begin
            st_nxt.fopen = 1'b0;
            st_nxt.phase = PH_PARA;
          end else begin
            st_nxt = clear_frame(PH_SKIP);
          end
        end else begin
          st_nxt.fopen = 1'b1;
        end
      end
      PH_PARA: begin
        if (is_zero) begin
          st_nxt = clear_frame(PH_MAGIC);
        end else if (is_sep) begin
          st_nxt.fopen = 1'b0;
        end else begin
          st_nxt.fopen = 1'b1;
        end
      end
      default: begin
        // skip to end of frame, unused codes too
        if (is_zero) begin
          st_nxt = clear_frame(PH_MAGIC);
        end
      end
    endcase
  end

  // result
  always_comb begin
    res.valid = 1'b0;
    res.kind  = K_DROP;
    res.value = '0;
    unique case (st.phase)
      PH_MAGIC: begin
        if (is_zero) begin
          res.valid = (st.mpos != '0) || st.mmis;
        end else if (is_sep) begin
          res.valid = !magic_ok;
        end
      end
      PH_TYPE: begin
        if (is_zero) begin
          res.valid = 1'b1;
        end else if (is_sep) begin
          res.valid = 1'b1;
          if (type_ok) begin
            res.kind  = K_TYPE;
            res.value = st.htype;
          end
        end
      end
      PH_CMD: begin
        res.valid = 1'b1;
        if (!is_zero && is_sep && st.fopen) begin
          res.kind = K_CMD_END;
        end else if (!is_zero && !is_sep) begin
          res.kind  = K_CMD_BYTE;
          res.value = byte_in;
        end
      end
      PH_PARA: begin
        if (is_zero) begin
          res.valid = 1'b1;
          res.kind  = K_FRAME_END;
          res.value = {{(BYTE_W-1){1'b0}}, st.fopen};
        end else if (is_sep) begin
          res.valid = st.fopen;
          res.kind  = K_PAR_END;
        end else begin
          res.valid = 1'b1;
          res.kind  = K_PAR_BYTE;
          res.value = byte_in;
        end
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
  end

endmodule
